// ===== hw/rtl/tcw_pkg.sv =====
// shared types and constants for the text terminal cell writer
package tcw_pkg;

    // item field widths
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int ROW_FIELD_W = 7;
    localparam int COL_FIELD_W = 7;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 32;
    localparam int CELL_W      = CHAR_W + COLOR_W;

    // control characters
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

    // tuser code for the kind of input item
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PHYS,
        ST_MULT,
        ST_ACCESS,
        ST_SCROLL_PHYS,
        ST_SCROLL_MULT,
        ST_SCROLL_CLEAR,
        ST_DONE
    } state_t;

    // decoded kind of the held item
    typedef enum logic [2:0] {
        OP_READ,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_PRINT
    } op_t;

    // source of the logical row for address generation
    typedef enum logic [1:0] {
        ROW_READ,
        ROW_CURSOR,
        ROW_BOTTOM
    } row_src_t;

    // cell store access
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_INIT,
        MEM_CLEAR_ROW,
        MEM_WRITE_CHAR,
        MEM_WRITE_BLANK,
        MEM_READ
    } mem_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load_item;
        logic     cursor_x_clr;
        logic     cursor_x_inc;
        logic     cursor_x_dec;
        logic     cursor_y_inc;
        logic     scroll;
        row_src_t row_src;
        logic     phys_load;
        logic     addr_load;
        logic     sweep_clr;
        logic     sweep_inc;
        mem_op_t  mem_op;
        logic     out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        op_t  op;
        logic x_zero;
        logic x_full;
        logic y_last;
        logic read_in_range;
        logic sweep_cell_last;
        logic sweep_col_last;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/tcw_controller.sv =====
// sequencing state machine of the text terminal cell writer
module tcw_controller (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  tcw_pkg::status_t status,
    output tcw_pkg::cmd_t   cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (status.sweep_cell_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (status.op)
                    OP_READ:      state_next = status.read_in_range ? ST_PHYS : ST_DONE;
                    OP_NEWLINE:   state_next = status.y_last ? ST_SCROLL_PHYS : ST_DONE;
                    OP_RETURN:    state_next = ST_DONE;
                    OP_BACKSPACE: state_next = status.x_zero ? ST_DONE : ST_PHYS;
                    OP_PRINT: begin
                        state_next = (status.x_full && status.y_last) ? ST_SCROLL_PHYS
                                                                       : ST_PHYS;
                    end
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_PHYS:        state_next = ST_MULT;
            ST_MULT:        state_next = ST_ACCESS;
            ST_ACCESS:      state_next = ST_DONE;
            ST_SCROLL_PHYS: state_next = ST_SCROLL_MULT;
            ST_SCROLL_MULT: state_next = ST_SCROLL_CLEAR;
            ST_SCROLL_CLEAR: begin
                if (status.sweep_col_last) begin
                    state_next = (status.op == OP_PRINT) ? ST_PHYS : ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default:        state_next = ST_INIT;
        endcase
    end

    // command outputs
    always_comb begin
        cmd      = '0;
        cmd.row_src = ROW_CURSOR;
        cmd.mem_op  = MEM_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.mem_op    = MEM_INIT;
                cmd.sweep_inc = 1'b1;
            end
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_DECODE: begin
                unique case (status.op)
                    OP_NEWLINE: begin
                        if (status.y_last) begin
                            cmd.scroll = 1'b1;
                        end else begin
                            cmd.cursor_x_clr = 1'b1;
                            cmd.cursor_y_inc = 1'b1;
                        end
                    end
                    OP_RETURN: begin
                        cmd.cursor_x_clr = 1'b1;
                    end
                    OP_BACKSPACE: begin
                        cmd.cursor_x_dec = !status.x_zero;
                    end
                    OP_PRINT: begin
                        if (status.x_full) begin
                            if (status.y_last) begin
                                cmd.scroll = 1'b1;
                            end else begin
                                cmd.cursor_x_clr = 1'b1;
                                cmd.cursor_y_inc = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_PHYS: begin
                cmd.row_src   = (status.op == OP_READ) ? ROW_READ : ROW_CURSOR;
                cmd.phys_load = 1'b1;
            end
            ST_MULT: begin
                cmd.addr_load = 1'b1;
            end
            ST_ACCESS: begin
                unique case (status.op)
                    OP_READ:      cmd.mem_op = MEM_READ;
                    OP_BACKSPACE: cmd.mem_op = MEM_WRITE_BLANK;
                    OP_PRINT: begin
                        cmd.mem_op       = MEM_WRITE_CHAR;
                        cmd.cursor_x_inc = 1'b1;
                    end
                    default:      cmd.mem_op = MEM_NONE;
                endcase
            end
            ST_SCROLL_PHYS: begin
                cmd.row_src   = ROW_BOTTOM;
                cmd.phys_load = 1'b1;
            end
            ST_SCROLL_MULT: begin
                cmd.addr_load = 1'b1;
                cmd.sweep_clr = 1'b1;
            end
            ST_SCROLL_CLEAR: begin
                cmd.mem_op    = MEM_CLEAR_ROW;
                cmd.sweep_inc = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// cursor, ring base, address generation, cell store and result register
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]   m_tdata,
    input  tcw_pkg::cmd_t                   cmd,
    output tcw_pkg::status_t                status
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int X_W   = $clog2(COLUMNS + 1);
    localparam int C_W   = $clog2(COLUMNS);
    localparam int A_W   = $clog2(CELLS);

    // held item
    logic                   item_func_reg;
    logic [CHAR_W-1:0]      item_char_reg;
    logic [COLOR_W-1:0]     item_color_reg;
    logic [ROW_FIELD_W-1:0] item_row_reg;
    logic [COL_FIELD_W-1:0] item_col_reg;
    op_t                    op_dec;

    // cursor and ring state
    logic [X_W-1:0]   cursor_x_reg;
    logic [ROW_W-1:0] cursor_y_reg;
    logic [ROW_W-1:0] base_reg;
    logic             scrolled_reg;

    // address generation
    logic [ROW_W-1:0] row_sel;
    logic [ROW_W:0]   row_sum;
    logic [ROW_W-1:0] phys_row_reg;
    logic [ROW_W-1:0] phys_row_next;
    logic [A_W-1:0]   row_addr_reg;
    logic [A_W-1:0]   sweep_reg;
    logic [C_W-1:0]   col_sel;
    logic [A_W-1:0]   mem_addr;
    logic             mem_we;
    logic [CELL_W-1:0] mem_wdata;

    // cell store, color in the upper byte
    logic [CELL_W-1:0] cell_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    // result register
    logic                   m_tvalid_reg;
    logic [CHAR_W-1:0]      out_char_reg;
    logic [COLOR_W-1:0]     out_color_reg;
    logic [COL_FIELD_W-1:0] out_col_reg;
    logic [ROW_FIELD_W-1:0] out_row_reg;
    logic                   out_scrolled_reg;

    logic read_in_range;

    // latch the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_func_reg  <= s_tuser;
            item_char_reg  <= s_tdata[CHAR_W-1:0];
            item_color_reg <= s_tdata[CHAR_W+COLOR_W-1:CHAR_W];
            item_row_reg   <= s_tdata[CHAR_W+COLOR_W+ROW_FIELD_W-1:CHAR_W+COLOR_W];
            item_col_reg   <= s_tdata[CHAR_W+COLOR_W+ROW_FIELD_W+COL_FIELD_W-1:
                                      CHAR_W+COLOR_W+ROW_FIELD_W];
        end
    end

    // decode the held item
    always_comb begin
        if (item_func_reg == FUNC_READ) begin
            op_dec = OP_READ;
        end else begin
            case (item_char_reg)
                CHAR_NEWLINE:   op_dec = OP_NEWLINE;
                CHAR_RETURN:    op_dec = OP_RETURN;
                CHAR_BACKSPACE: op_dec = OP_BACKSPACE;
                default:        op_dec = OP_PRINT;
            endcase
        end
    end

    assign read_in_range = (32'(item_row_reg) < ROWS) && (32'(item_col_reg) < COLUMNS);

    // status toward the controller
    assign status.op              = op_dec;
    assign status.x_zero          = (cursor_x_reg == '0);
    assign status.x_full          = (cursor_x_reg == X_W'(COLUMNS));
    assign status.y_last          = (cursor_y_reg == ROW_W'(ROWS - 1));
    assign status.read_in_range   = read_in_range;
    assign status.sweep_cell_last = (sweep_reg == A_W'(CELLS - 1));
    assign status.sweep_col_last  = (sweep_reg == A_W'(COLUMNS - 1));
    assign status.out_free        = !m_tvalid_reg || m_tready;

    // cursor, ring base and scroll flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            base_reg     <= '0;
            scrolled_reg <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                scrolled_reg <= 1'b0;
            end
            if (cmd.scroll) begin
                cursor_x_reg <= '0;
                cursor_y_reg <= ROW_W'(ROWS - 1);
                base_reg     <= (base_reg == ROW_W'(ROWS - 1)) ? '0 : base_reg + 1'b1;
                scrolled_reg <= 1'b1;
            end
            if (cmd.cursor_x_clr) begin
                cursor_x_reg <= '0;
            end else if (cmd.cursor_x_inc) begin
                cursor_x_reg <= cursor_x_reg + 1'b1;
            end else if (cmd.cursor_x_dec) begin
                cursor_x_reg <= cursor_x_reg - 1'b1;
            end
            if (cmd.cursor_y_inc) begin
                cursor_y_reg <= cursor_y_reg + 1'b1;
            end
        end
    end

    // logical to physical row, one wrap at most
    always_comb begin
        case (cmd.row_src)
            ROW_READ:   row_sel = ROW_W'(32'(item_row_reg));
            ROW_BOTTOM: row_sel = ROW_W'(ROWS - 1);
            default:    row_sel = cursor_y_reg;
        endcase
        row_sum = (ROW_W + 1)'(base_reg) + (ROW_W + 1)'(row_sel);
        if (row_sum >= (ROW_W + 1)'(ROWS)) begin
            phys_row_next = ROW_W'(row_sum - (ROW_W + 1)'(ROWS));
        end else begin
            phys_row_next = ROW_W'(row_sum);
        end
    end

    // row address registers and sweep counter
    always_ff @(posedge aclk) begin
        if (cmd.phys_load) begin
            phys_row_reg <= phys_row_next;
        end
        if (cmd.addr_load) begin
            row_addr_reg <= A_W'(phys_row_reg) * A_W'(COLUMNS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_clr) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_inc) begin
            sweep_reg <= sweep_reg + 1'b1;
        end
    end

    // store port address and write data
    always_comb begin
        col_sel   = (status.op == OP_READ) ? C_W'(32'(item_col_reg))
                                           : C_W'(cursor_x_reg);
        mem_addr  = row_addr_reg + A_W'(col_sel);
        mem_we    = 1'b0;
        mem_wdata = {{COLOR_W{1'b0}}, CHAR_SPACE};
        case (cmd.mem_op)
            MEM_INIT: begin
                mem_addr  = sweep_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            MEM_CLEAR_ROW: begin
                mem_addr = row_addr_reg + sweep_reg;
                mem_we   = 1'b1;
            end
            MEM_WRITE_BLANK: begin
                mem_we = 1'b1;
            end
            MEM_WRITE_CHAR: begin
                mem_we    = 1'b1;
                mem_wdata = {item_color_reg, item_char_reg};
            end
            default: begin
            end
        endcase
    end

    // cell store with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_op == MEM_READ) begin
            rd_data_reg <= cell_mem[mem_addr];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (status.op == OP_READ && read_in_range) begin
                out_char_reg  <= rd_data_reg[CHAR_W-1:0];
                out_color_reg <= rd_data_reg[CELL_W-1:CHAR_W];
            end else begin
                out_char_reg  <= '0;
                out_color_reg <= '0;
            end
            out_col_reg      <= COL_FIELD_W'(cursor_x_reg);
            out_row_reg      <= ROW_FIELD_W'(cursor_y_reg);
            out_scrolled_reg <= (status.op != OP_READ) && scrolled_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_scrolled_reg, out_row_reg, out_col_reg,
                       out_color_reg, out_char_reg};

endmodule

// ===== hw/rtl/text_terminal_cell_writer.sv =====
// top level of the text terminal cell writer
// Character-cell terminal with a ring of ROWS rows by COLUMNS columns.
// Input items (s_ channel): tuser selects put (0) or read (1); tdata carries
// the character, its color and the row and column of a read. Every item gives
// exactly one result item (m_ channel) with the read cell (zero for a put or
// a read outside the store), the cursor after the item and a scroll flag.
// Steps per item, from acceptance to the result register:
//   return, backspace at column 0, newline without scroll, read out of range:
//   decode; read, print, backspace: decode, row wrap add, constant multiply,
//   store access; an item that scrolls adds the bottom row address and clears
//   the new bottom row, one cell per cycle through the single store write port.
// One item is worked on at a time; the next is accepted from the cycle after
// the previous result is loaded, even while that result waits on m_tready.
// A stalled receiver holds the result register; the block then waits with the
// following result until the register frees.
// After reset (aresetn low, synchronous) the cursor and ring base are zero and
// the store is cleared to zeros by a pass over all ROWS * COLUMNS cells,
// during which s_tready stays low.
module text_terminal_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // char_code[7:0], color[15:8], read_row[22:16], read_col[29:23], zeros
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic                          s_tuser,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_char[7:0], cell_color[15:8], cursor_col[22:16], cursor_row[29:23],
    // scrolled[30], zero[31]
    output logic [tcw_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcw_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    tcw_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and arithmetic
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== verif/tcw_checker.sv =====
// checker for the text terminal cell writer: terminal model, reply queue and compare
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // char_code[7:0], color[15:8], read_row[22:16], read_col[29:23], zeros
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_char[7:0], cell_color[15:8], cursor_col[22:16], cursor_row[29:23],
    // scrolled[30], zero[31]
    input  logic [tcw_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            mismatches,
    output int                            replies_pending,
    output int                            scrolls_done
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    // one reply item, packed as on m_tdata below the pad bit
    typedef struct packed {
        logic                   scrolled;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
        logic [COLOR_W-1:0]     cell_color;
        logic [CHAR_W-1:0]      cell_char;
    } cell_reply_t;

    // terminal state as the block should hold it
    logic [CHAR_W-1:0]  glyph_mem [CELLS];
    logic [COLOR_W-1:0] shade_mem [CELLS];
    int                 cur_x;
    int                 cur_y;
    int                 ring_base;
    int                 scroll_total;
    int                 replies_seen;
    cell_reply_t        reply_fifo [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: reply %0d %s got 0x%0h want 0x%0h",
                     $realtime, replies_seen, what, got, want);
    endtask

    // logical row and column to a cell of the ring
    function automatic int cell_addr(input int row, input int col);
        return ((ring_base + row) % ROWS) * COLUMNS + col;
    endfunction

    // cursor to the start of the next row, scrolling the ring at the bottom
    function automatic logic advance_row();
        int k;
        cur_x = 0;
        cur_y++;
        if (cur_y >= ROWS) begin
            ring_base = (ring_base + 1) % ROWS;
            for (int c = 0; c < COLUMNS; c++) begin
                k = cell_addr(ROWS - 1, c);
                glyph_mem[k] = CHAR_SPACE;
                shade_mem[k] = '0;
            end
            cur_y = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one input item to the terminal and form its reply
    function automatic cell_reply_t apply_item(input logic func,
                                               input logic [S_TDATA_W-1:0] data);
        logic [CHAR_W-1:0]      ch;
        logic [COLOR_W-1:0]     shade;
        logic [ROW_FIELD_W-1:0] rrow;
        logic [COL_FIELD_W-1:0] rcol;
        cell_reply_t            r;
        int                     k;
        ch    = data[7:0];
        shade = data[15:8];
        rrow  = data[22:16];
        rcol  = data[29:23];
        r     = '0;
        if (func == FUNC_READ) begin
            if (rrow < ROWS && rcol < COLUMNS) begin
                k = cell_addr(rrow, rcol);
                r.cell_char  = glyph_mem[k];
                r.cell_color = shade_mem[k];
            end
        end else if (ch == CHAR_NEWLINE) begin
            r.scrolled = advance_row();
        end else if (ch == CHAR_RETURN) begin
            cur_x = 0;
        end else if (ch == CHAR_BACKSPACE) begin
            // at column 0 nothing happens
            if (cur_x > 0) begin
                cur_x--;
                k = cell_addr(cur_y, cur_x);
                glyph_mem[k] = CHAR_SPACE;
                shade_mem[k] = '0;
            end
        end else begin
            // full row wraps (and maybe scrolls) before the write
            if (cur_x >= COLUMNS)
                r.scrolled = advance_row();
            k = cell_addr(cur_y, cur_x);
            glyph_mem[k] = ch;
            shade_mem[k] = shade;
            cur_x++;
        end
        r.cursor_col = cur_x[COL_FIELD_W-1:0];
        r.cursor_row = cur_y[ROW_FIELD_W-1:0];
        return r;
    endfunction

    // watch both channels: compare replies, then model accepted items
    always @(posedge aclk) begin
        cell_reply_t got;
        cell_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                glyph_mem[i] = '0;
                shade_mem[i] = '0;
            end
            cur_x        = 0;
            cur_y        = 0;
            ring_base    = 0;
            scroll_total = 0;
            replies_seen = 0;
            reply_fifo.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[30:0];
                if (reply_fifo.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata, '0);
                end else begin
                    want = reply_fifo.pop_front();
                    if (got.cell_char !== want.cell_char)
                        report_mismatch("cell_char", got.cell_char, want.cell_char);
                    if (got.cell_color !== want.cell_color)
                        report_mismatch("cell_color", got.cell_color, want.cell_color);
                    if (got.cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", got.cursor_col, want.cursor_col);
                    if (got.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
                    if (got.scrolled !== want.scrolled)
                        report_mismatch("scrolled", got.scrolled, want.scrolled);
                    if (m_tdata[31] !== 1'b0)
                        report_mismatch("pad bit", m_tdata[31], 1'b0);
                end
                replies_seen++;
            end
            if (s_tvalid && s_tready) begin
                want = apply_item(s_tuser, s_tdata);
                if (want.scrolled)
                    scroll_total++;
                reply_fifo.push_back(want);
            end
        end
        replies_pending <= reply_fifo.size();
        scrolls_done    <= scroll_total;
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the text terminal cell writer: clock, reset, stimulus, verdict
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 128;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 500;
    localparam int ITEM_CEILING   = 3000;
    localparam int MIN_SCROLLS    = 8;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 200;
    localparam int QUIET_LIMIT    = 40000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    int   mismatches;
    int   replies_pending;
    int   scrolls_done;
    int   items_sent = 0;
    int   quiet_cycles = 0;
    logic no_gaps = 1'b0;
    logic hold_rx = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    text_terminal_cell_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tcw_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .replies_pending (replies_pending),
        .scrolls_done    (scrolls_done)
    );

    // offer one item and wait until it is taken, with a random gap first unless no_gaps is set
    task automatic send_item(input logic func, input logic [CHAR_W-1:0] ch,
                             input logic [COLOR_W-1:0] shade,
                             input logic [ROW_FIELD_W-1:0] row,
                             input logic [COL_FIELD_W-1:0] col);
        if (!no_gaps && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 33);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, col, row, shade, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // put item; the read fields are ignored by the block and carry noise
    task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] shade);
        send_item(FUNC_PUT, ch, shade, 7'($urandom), 7'($urandom));
    endtask

    // read item; the character fields carry noise
    task automatic read_cell(input logic [ROW_FIELD_W-1:0] row,
                             input logic [COL_FIELD_W-1:0] col);
        send_item(FUNC_READ, 8'($urandom), 8'($urandom), row, col);
    endtask

    // any byte that is stored as a character, control bytes included
    function automatic logic [CHAR_W-1:0] any_glyph();
        logic [CHAR_W-1:0] c;
        do c = 8'($urandom);
        while (c == CHAR_NEWLINE || c == CHAR_RETURN || c == CHAR_BACKSPACE);
        return c;
    endfunction

    // stop offering and wait until every reply is back
    task automatic wait_replies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_pending != 0);
    endtask

    // result side: random stalls unless no_gaps is set, one long hold-off on request
    initial begin
        logic held;
        held = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_rx && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= no_gaps || ($urandom_range(99) >= 33);
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        int burst;
        int pick;
        int n;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= FUNC_PUT;
        s_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, each kind of item, corner cases
        read_cell(7'd0, 7'd0);
        put_char(8'h00, 8'hFF);
        put_char(8'hFF, 8'h00);
        put_char(8'h01, 8'hAA);
        put_char(8'h7F, 8'h55);
        read_cell(7'd0, 7'd0);
        read_cell(7'd0, 7'd3);
        read_cell(7'd127, 7'd79);
        read_cell(7'd0, 7'd80);
        read_cell(7'd127, 7'd127);
        put_char(CHAR_BACKSPACE, 8'h00);
        read_cell(7'd0, 7'd3);
        put_char(CHAR_RETURN, 8'hFF);
        // backspace at column 0 leaves everything alone
        put_char(CHAR_BACKSPACE, 8'hFF);
        put_char(CHAR_NEWLINE, 8'h00);
        put_char(8'h41, 8'h07);
        put_char(CHAR_SPACE, 8'hFF);
        put_char(8'h09, 8'h80);
        read_cell(7'd1, 7'd0);
        put_char(CHAR_NEWLINE, 8'hFF);
        read_cell(7'd0, 7'd1);
        wait_replies();

        // random bursts of well-formed text with noise in between
        burst = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS
               || (scrolls_done < MIN_SCROLLS && items_sent < ITEM_CEILING)) begin
            no_gaps <= (burst >= 12 && burst < 20);
            if (burst == 3)
                hold_rx <= 1'b1;
            if (burst == 8)
                wait_replies();
            pick = $urandom_range(99);
            if (pick < 30) begin
                // short line ended by newline or return
                n = $urandom_range(0, 10);
                repeat (n) put_char(any_glyph(), 8'($urandom));
                put_char(($urandom_range(4) == 0) ? CHAR_RETURN : CHAR_NEWLINE,
                         8'($urandom));
            end else if (pick < 50) begin
                // run of newlines to reach the bottom and scroll
                n = $urandom_range(10, 40);
                repeat (n) put_char(CHAR_NEWLINE, 8'($urandom));
            end else if (pick < 58) begin
                // fill a row exactly, then act on the full row
                put_char(CHAR_RETURN, 8'($urandom));
                repeat (COLUMNS) put_char(any_glyph(), 8'($urandom));
                case ($urandom_range(3))
                    0: begin
                        n = $urandom_range(1, 3);
                        repeat (n) put_char(CHAR_BACKSPACE, 8'($urandom));
                    end
                    1: put_char(any_glyph(), 8'($urandom));
                    2: put_char(CHAR_NEWLINE, 8'($urandom));
                    default: read_cell(7'($urandom), 7'($urandom_range(COLUMNS - 1)));
                endcase
            end else if (pick < 70) begin
                // backspaces, often running past column 0
                n = $urandom_range(1, 6);
                repeat (n) put_char(CHAR_BACKSPACE, 8'($urandom));
            end else if (pick < 90) begin
                // reads near the top, near the bottom and anywhere
                n = $urandom_range(1, 6);
                repeat (n) begin
                    case ($urandom_range(2))
                        0: read_cell(7'($urandom_range(7)), 7'($urandom_range(15)));
                        1: read_cell(7'($urandom_range(ROWS - 8, ROWS - 1)),
                                     7'($urandom_range(15)));
                        default: read_cell(7'($urandom), 7'($urandom));
                    endcase
                end
            end else begin
                // return and overwrite the start of the row
                put_char(CHAR_RETURN, 8'($urandom));
                n = $urandom_range(0, 5);
                repeat (n) put_char(any_glyph(), 8'($urandom));
            end
            burst++;
        end

        no_gaps <= 1'b0;
        wait_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && replies_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
